### hw/rtl/owbm_pkg.sv
// Shared types, codes and constants of the 1-wire bus master.
package owbm_pkg;

  localparam int NUM_CHANNELS = 2;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_RESET_LOW       = 3'd0,
    REG_PRESENCE_SAMPLE = 3'd1,
    REG_RESET_TOTAL     = 3'd2,
    REG_READ_LOW        = 3'd3,
    REG_READ_SAMPLE     = 3'd4,
    REG_WRITE_ZERO_LOW  = 3'd5,
    REG_WRITE_ONE_LOW   = 3'd6,
    REG_SLOT            = 3'd7
  } reg_idx_t;

  localparam logic [9:0] RESET_LOW_DEF       = 10'd500;
  localparam logic [9:0] PRESENCE_SAMPLE_DEF = 10'd70;
  localparam logic [9:0] RESET_TOTAL_DEF     = 10'd480;
  localparam logic [7:0] READ_LOW_DEF        = 8'd10;
  localparam logic [7:0] READ_SAMPLE_DEF     = 8'd20;
  localparam logic [7:0] WRITE_ZERO_LOW_DEF  = 8'd40;
  localparam logic [7:0] WRITE_ONE_LOW_DEF   = 8'd1;
  localparam logic [7:0] SLOT_DEF            = 8'd60;

  typedef struct packed {
    logic [9:0] reset_low_us;
    logic [9:0] presence_sample_us;
    logic [9:0] reset_total_us;
    logic [7:0] read_low_us;
    logic [7:0] read_sample_us;
    logic [7:0] write_zero_low_us;
    logic [7:0] write_one_low_us;
    logic [7:0] slot_us;
  } cfg_t;

  typedef struct packed {
    cmd_t       cmd;
    logic       channel;
    logic [7:0] tx_byte;
    logic       line_level;
  } item_t;

  typedef struct packed {
    logic       drive_low;
    logic       drive_channel;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] rx_data;
    logic       rejected;
  } result_t;

endpackage

### hw/rtl/owbm_cfg_regs.sv
// Timing configuration registers of the 1-wire bus master.
module owbm_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  owbm_pkg::reg_idx_t  wr_index,
  input  logic [9:0]          wr_data,
  output owbm_pkg::cfg_t      cfg
);
  import owbm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_us       <= RESET_LOW_DEF;
      cfg.presence_sample_us <= PRESENCE_SAMPLE_DEF;
      cfg.reset_total_us     <= RESET_TOTAL_DEF;
      cfg.read_low_us        <= READ_LOW_DEF;
      cfg.read_sample_us     <= READ_SAMPLE_DEF;
      cfg.write_zero_low_us  <= WRITE_ZERO_LOW_DEF;
      cfg.write_one_low_us   <= WRITE_ONE_LOW_DEF;
      cfg.slot_us            <= SLOT_DEF;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_RESET_LOW:       cfg.reset_low_us       <= wr_data;
        REG_PRESENCE_SAMPLE: cfg.presence_sample_us <= wr_data;
        REG_RESET_TOTAL:     cfg.reset_total_us     <= wr_data;
        REG_READ_LOW:        cfg.read_low_us        <= wr_data[7:0];
        REG_READ_SAMPLE:     cfg.read_sample_us     <= wr_data[7:0];
        REG_WRITE_ZERO_LOW:  cfg.write_zero_low_us  <= wr_data[7:0];
        REG_WRITE_ONE_LOW:   cfg.write_one_low_us   <= wr_data[7:0];
        REG_SLOT:            cfg.slot_us            <= wr_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/owbm_seq.sv
// Bus sequencer: one microsecond step of reset, write and read timing per word.
module owbm_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              step_en,
  input  owbm_pkg::cfg_t    cfg,
  input  owbm_pkg::item_t   item,
  output owbm_pkg::result_t res
);
  import owbm_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_RST_LOW = 3'd1,
    PH_RST_REL = 3'd2,
    PH_WRITE   = 3'd3,
    PH_READ    = 3'd4
  } phase_t;

  phase_t     phase, phase_next;
  logic [9:0] tick_count, tick_count_next;
  logic [2:0] bit_number, bit_number_next;
  logic [7:0] shift_data, shift_data_next;
  logic       active_channel, active_channel_next;
  logic       presence_flag, presence_flag_next;
  logic [7:0] received_byte, received_byte_next;

  phase_t     ph0;
  logic [9:0] tc0;
  logic [10:0] tc_inc;
  logic [2:0] bn0;
  logic [7:0] sd0;
  logic [7:0] low_time;
  logic       start, drive, done, slot_end;

  always_comb begin
    start = (item.cmd != CMD_NONE) && (phase == PH_IDLE);

    ph0                 = phase;
    tc0                 = tick_count;
    bn0                 = bit_number;
    sd0                 = shift_data;
    active_channel_next = active_channel;
    presence_flag_next  = presence_flag;
    if (start) begin
      active_channel_next = (int'(item.channel) < NUM_CHANNELS) ? item.channel : 1'b0;
      tc0 = '0;
      bn0 = '0;
      unique case (item.cmd)
        CMD_RESET: begin
          ph0                = PH_RST_LOW;
          presence_flag_next = 1'b0;
        end
        CMD_WRITE: begin
          ph0 = PH_WRITE;
          sd0 = item.tx_byte;
        end
        default: begin
          ph0 = PH_READ;
          sd0 = '0;
        end
      endcase
    end

    tc_inc             = {1'b0, tc0} + 11'd1;
    phase_next         = ph0;
    tick_count_next    = tc_inc[9:0];
    bit_number_next    = bn0;
    shift_data_next    = sd0;
    received_byte_next = received_byte;
    drive              = 1'b0;
    done               = 1'b0;
    low_time           = sd0[bn0] ? cfg.write_one_low_us : cfg.write_zero_low_us;
    slot_end           = tc_inc >= {3'b0, cfg.slot_us};

    unique case (ph0)
      PH_RST_LOW: begin
        drive = 1'b1;
        if (tc_inc >= {1'b0, cfg.reset_low_us}) begin
          phase_next      = PH_RST_REL;
          tick_count_next = '0;
        end
      end
      PH_RST_REL: begin
        if (tc0 == cfg.presence_sample_us) presence_flag_next = ~item.line_level;
        if (tc_inc >= {1'b0, cfg.reset_total_us}) begin
          phase_next      = PH_IDLE;
          tick_count_next = '0;
          done            = 1'b1;
        end
      end
      PH_WRITE, PH_READ: begin
        if (ph0 == PH_WRITE) begin
          drive = tc0 < {2'b0, low_time};
        end else begin
          drive = tc0 < {2'b0, cfg.read_low_us};
          if (tc0 == {2'b0, cfg.read_sample_us} && item.line_level)
            shift_data_next[bn0] = 1'b1;
        end
        if (slot_end) begin
          tick_count_next = '0;
          bit_number_next = bn0 + 3'd1;
          if (bn0 == 3'd7) begin
            phase_next = PH_IDLE;
            done       = 1'b1;
            if (ph0 == PH_READ) received_byte_next = shift_data_next;
          end
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        tick_count_next = tc0;
      end
    endcase

    res.drive_low     = drive;
    res.drive_channel = active_channel_next;
    res.busy_res      = phase_next != PH_IDLE;
    res.done_res      = done;
    res.presence      = presence_flag_next;
    res.rx_data       = received_byte_next;
    res.rejected      = (item.cmd != CMD_NONE) && (phase != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      tick_count     <= '0;
      bit_number     <= '0;
      shift_data     <= '0;
      active_channel <= 1'b0;
      presence_flag  <= 1'b0;
      received_byte  <= '0;
    end else if (step_en) begin
      phase          <= phase_next;
      tick_count     <= tick_count_next;
      bit_number     <= bit_number_next;
      shift_data     <= shift_data_next;
      active_channel <= active_channel_next;
      presence_flag  <= presence_flag_next;
      received_byte  <= received_byte_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    step_en && phase == PH_IDLE && item.cmd == CMD_NONE |=> phase == PH_IDLE)
    else $error("sequencer left idle without a command");

  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    step_en && res.rejected |-> phase != PH_IDLE)
    else $error("command rejected while idle");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_WRITE || phase == PH_READ) |-> tick_count <= {2'b0, cfg.slot_us})
    else $error("slot tick count ran past slot length");

  a_bit_phase: assert property (@(posedge clk) disable iff (rst)
    bit_number != 3'd0 |-> (phase == PH_WRITE || phase == PH_READ))
    else $error("bit number set outside a byte transfer");
`endif

endmodule

### hw/rtl/one_wire_bus_master.sv
// Top level of the two-channel 1-wire bus master.
// Each accepted word is one microsecond tick; one tick is taken every clock cycle
// when the result side keeps up. A word passes an input register, one step of the
// bus sequencer, and the result register. The sequencer state (phase, tick and bit
// counters, shift byte) is advanced once per word in that single step.
// Configuration writes are registered and always ready.
module one_wire_bus_master (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  owbm_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output owbm_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [9:0]        cfg_data
);
  import owbm_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    item_q_valid;
  result_t step_res;
  logic    advance;

  assign cfg_ready  = 1'b1;
  assign advance    = item_q_valid && (!result_valid || result_ready);
  assign item_ready = !item_q_valid || advance;

  owbm_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (reg_idx_t'(cfg_index)),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  owbm_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .cfg     (cfg),
    .item    (item_q),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_ready) item_q_valid <= item_valid;
      if (advance) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
    if (item_valid && item_ready) item_q <= item;
    if (advance) result <= step_res;
  end

endmodule
